>>> sv/typed_draw_batch_allocator_macros.svh
// Assertion macros shared by the checker of the batch allocator.
// No dependencies; each macro expands to one labeled concurrent assertion.
`ifndef TYPED_DRAW_BATCH_ALLOCATOR_MACROS_SVH
`define TYPED_DRAW_BATCH_ALLOCATOR_MACROS_SVH

// Same-cycle implication under synchronous active-low reset.
`define TDBA_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tdba assertion failed");

// Next-cycle implication under synchronous active-low reset.
`define TDBA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tdba assertion failed");

`endif

>>> sv/tdba_pkg.sv
// Types and codes of the typed draw batch allocator.
// No dependencies; used by every module of the block.
package tdba_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;

    // Exclusive end bound for the text kind, one past the 16-bit slot range.
    localparam logic [16:0] TEXT_LIMIT = 17'h10000;

    typedef enum logic [1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_READ  = 2'd2,
        ACT_NONE  = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        KIND_ATLAS     = 2'd0,
        KIND_PRIMITIVE = 2'd1,
        KIND_TEXT      = 2'd2,
        KIND_NONE      = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_OVER_CAP   = 2'd1,
        ST_TABLE_FULL = 2'd2,
        ST_BAD_SLOT   = 2'd3
    } t_status;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ALIGN_ATLAS     = 3'd0,
        CFG_ALIGN_PRIMITIVE = 3'd1,
        CFG_ALIGN_TEXT      = 3'd2,
        CFG_CAP_ATLAS       = 3'd3,
        CFG_CAP_PRIMITIVE   = 3'd4
    } t_cfg_reg;

    typedef struct packed {
        logic [1:0]  action;
        logic [1:0]  item_kind;
        logic [11:0] increment;
        logic [7:0]  batch_slot;
    } t_request;

    typedef struct packed {
        logic [15:0] start_index;
        logic [7:0]  batch_index;
        logic        new_batch;
        logic [1:0]  status;
        logic [8:0]  batch_total;
        logic [1:0]  read_kind;
        logic [15:0] read_start;
        logic [15:0] read_count;
    } t_result;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] start;
        logic [15:0] count;
    } t_record;

endpackage

>>> sv/tdba_batch_ram.sv
// Batch record store: one write port, one read port with registered data.
// Depends on tdba_pkg for the record type.
module tdba_batch_ram #(
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  tdba_pkg::t_record        i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output tdba_pkg::t_record        o_rdata
);

    tdba_pkg::t_record r_mem [DEPTH];
    tdba_pkg::t_record r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/typed_draw_batch_allocator.sv
// Top level of the typed draw batch allocator: slot counters, batch grouping, result pipeline.
// Depends on tdba_pkg and tdba_batch_ram.
//
//  channel   | direction | handshake                  | payload
//  ----------+-----------+----------------------------+---------------------------
//  request   | in        | i_req_valid / o_req_ready  | i_req (tdba_pkg::t_request)
//  result    | out       | o_res_valid / i_res_ready  | o_res (tdba_pkg::t_result)
//  config    | in        | i_cfg_valid / o_cfg_ready  | i_cfg_index, i_cfg_data
//
// One request beat per cycle while o_req_ready is high; each result passes the middle stage
// and then the output register. Adds and clears update the counters in the accept cycle;
// reads go through the registered read port of the record memory, merged in the middle stage.
// A stalled result holds in the output register; the middle stage keeps one more beat
// and the request side stalls only when both are full.
// Sync reset clears counters, config and valid flags; records are only read once written.
module typed_draw_batch_allocator #(
    parameter int BATCH_SLOTS = 256,
    parameter int ALIGN_BYTES = 256
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_req_valid,
    output logic                               o_req_ready,
    input  tdba_pkg::t_request                 i_req,
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output tdba_pkg::t_result                  o_res,
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [tdba_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [tdba_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int AW       = $clog2(BATCH_SLOTS);
    localparam int CW       = $clog2(BATCH_SLOTS + 1);
    localparam int ALIGN_LG = $clog2(ALIGN_BYTES + 1) - 1;
    localparam logic [3:0]    ALIGN_LG_V = 4'(ALIGN_LG);
    localparam logic [CW-1:0] SLOTS_V    = CW'(BATCH_SLOTS);

    // configuration
    logic [3:0]  r_align_atlas;
    logic [3:0]  r_align_prim;
    logic [3:0]  r_align_text;
    logic [15:0] r_cap_atlas;
    logic [15:0] r_cap_prim;

    // allocator state
    logic [CW-1:0] r_count, n_count;
    logic [1:0]    r_open_kind, n_open_kind;
    logic [15:0]   r_next [3];
    logic [15:0]   n_next [3];
    logic [15:0]   r_open_start, n_open_start;
    logic [15:0]   r_open_count, n_open_count;

    // pipeline
    logic                r_s1_valid;
    logic                r_s1_rd_ok;
    tdba_pkg::t_result   r_s1_res;
    tdba_pkg::t_result   n_s1_res;
    logic                r_out_valid;
    tdba_pkg::t_result   r_out;
    tdba_pkg::t_result   out_res;

    logic          accept;
    logic          s1_move;
    logic          rd_ok;
    logic [15:0]   cur_next;
    logic [3:0]    lg_raw;
    logic [3:0]    lg_eff;
    logic [16:0]   limit;
    logic [16:0]   unit_m1;
    logic [16:0]   aligned;
    logic [16:0]   base;
    logic [16:0]   slot_end;
    logic          grow;
    logic          over_cap;
    logic          full;
    logic          add_ok;
    logic [CW-1:0] rec_idx;
    logic [CW+7:0] rec_idx_ext;
    logic [CW+8:0] total_ext;
    logic [CW+7:0] slot_ext;
    logic [CW+7:0] cnt_ext;

    logic                 mem_we;
    logic [AW-1:0]        mem_waddr;
    tdba_pkg::t_record    mem_wdata;
    logic                 mem_re;
    tdba_pkg::t_record    mem_rdata;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_align_atlas <= 4'd1;
            r_align_prim  <= 4'd1;
            r_align_text  <= 4'd3;
            r_cap_atlas   <= 16'hFFFF;
            r_cap_prim    <= 16'hFFFF;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tdba_pkg::CFG_ALIGN_ATLAS:     r_align_atlas <= i_cfg_data[3:0];
                tdba_pkg::CFG_ALIGN_PRIMITIVE: r_align_prim  <= i_cfg_data[3:0];
                tdba_pkg::CFG_ALIGN_TEXT:      r_align_text  <= i_cfg_data[3:0];
                tdba_pkg::CFG_CAP_ATLAS:       r_cap_atlas   <= i_cfg_data;
                tdba_pkg::CFG_CAP_PRIMITIVE:   r_cap_prim    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s1_move     = r_s1_valid && (!r_out_valid || i_res_ready);
    assign o_req_ready = !r_s1_valid || s1_move;
    assign accept      = i_req_valid && o_req_ready;

    always_comb begin
        case (i_req.item_kind)
            tdba_pkg::KIND_ATLAS: begin
                cur_next = r_next[0];
                lg_raw   = r_align_atlas;
                limit    = {1'b0, r_cap_atlas};
            end
            tdba_pkg::KIND_PRIMITIVE: begin
                cur_next = r_next[1];
                lg_raw   = r_align_prim;
                limit    = {1'b0, r_cap_prim};
            end
            default: begin
                cur_next = r_next[2];
                lg_raw   = r_align_text;
                limit    = tdba_pkg::TEXT_LIMIT;
            end
        endcase

        // alignment unit is capped at the byte alignment
        lg_eff   = (lg_raw > ALIGN_LG_V) ? ALIGN_LG_V : lg_raw;
        unit_m1  = (17'd1 << lg_eff) - 17'd1;
        aligned  = ({1'b0, cur_next} + unit_m1) & ~unit_m1;
        grow     = (r_open_kind == i_req.item_kind) && (r_count != '0);
        base     = grow ? {1'b0, cur_next} : aligned;
        slot_end = base + {5'd0, i_req.increment};
        over_cap = slot_end >= limit;
        full     = r_count >= SLOTS_V;
        add_ok   = grow ? !over_cap : (!over_cap && !full);
        rec_idx  = grow ? (r_count - CW'(1)) : r_count;

        slot_ext = {{CW{1'b0}}, i_req.batch_slot};
        cnt_ext  = {8'd0, r_count};
        rd_ok    = slot_ext < cnt_ext;

        n_count      = r_count;
        n_open_kind  = r_open_kind;
        n_next       = r_next;
        n_open_start = r_open_start;
        n_open_count = r_open_count;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = rec_idx[AW-1:0];
        mem_wdata    = '0;
        n_s1_res     = '0;

        if (i_req.action == tdba_pkg::ACT_ADD && i_req.item_kind != tdba_pkg::KIND_NONE) begin
            if (over_cap) begin
                n_s1_res.status = tdba_pkg::ST_OVER_CAP;
            end else if (!add_ok) begin
                n_s1_res.status = tdba_pkg::ST_TABLE_FULL;
            end else begin
                mem_we = accept;
                if (grow) begin
                    n_open_count = r_open_count + {4'd0, i_req.increment};
                end else begin
                    n_open_count = {4'd0, i_req.increment};
                    n_open_start = aligned[15:0];
                    n_open_kind  = i_req.item_kind;
                    n_count      = r_count + CW'(1);
                end
                case (i_req.item_kind)
                    tdba_pkg::KIND_ATLAS:     n_next[0] = slot_end[15:0];
                    tdba_pkg::KIND_PRIMITIVE: n_next[1] = slot_end[15:0];
                    default:                  n_next[2] = slot_end[15:0];
                endcase
                mem_wdata.kind        = i_req.item_kind;
                mem_wdata.start       = n_open_start;
                mem_wdata.count       = n_open_count;
                n_s1_res.start_index  = base[15:0];
                n_s1_res.new_batch    = !grow;
            end
        end else if (i_req.action == tdba_pkg::ACT_CLEAR) begin
            n_count     = '0;
            n_open_kind = tdba_pkg::KIND_NONE;
            n_next      = '{default: '0};
        end else if (i_req.action == tdba_pkg::ACT_READ) begin
            mem_re = accept && rd_ok;
            if (!rd_ok) begin
                n_s1_res.status = tdba_pkg::ST_BAD_SLOT;
            end
        end

        rec_idx_ext = {8'd0, rec_idx};
        if (n_s1_res.status == tdba_pkg::ST_OK
                && i_req.action == tdba_pkg::ACT_ADD
                && i_req.item_kind != tdba_pkg::KIND_NONE) begin
            n_s1_res.batch_index = rec_idx_ext[7:0];
        end
        total_ext            = {9'd0, n_count};
        n_s1_res.batch_total = total_ext[8:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_open_kind <= tdba_pkg::KIND_NONE;
            r_next      <= '{default: '0};
        end else if (accept) begin
            r_count     <= n_count;
            r_open_kind <= n_open_kind;
            r_next      <= n_next;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_open_start <= n_open_start;
            r_open_count <= n_open_count;
            r_s1_res     <= n_s1_res;
            r_s1_rd_ok   <= (i_req.action == tdba_pkg::ACT_READ) && rd_ok;
        end
    end

    tdba_batch_ram #(
        .DEPTH (BATCH_SLOTS)
    ) u_batch_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (slot_ext[AW-1:0]),
        .o_rdata (mem_rdata)
    );

    // read data is registered in the RAM and merged as the beat leaves the middle stage
    always_comb begin
        out_res = r_s1_res;
        if (r_s1_rd_ok) begin
            out_res.read_kind  = mem_rdata.kind;
            out_res.read_start = mem_rdata.start;
            out_res.read_count = mem_rdata.count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_move) begin
                r_s1_valid <= 1'b0;
            end
            if (s1_move) begin
                r_out_valid <= 1'b1;
            end else if (i_res_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move) begin
            r_out <= out_res;
        end
    end

    assign o_res_valid = r_out_valid;
    assign o_res       = r_out;

endmodule

>>> sv/tdba_checker.sv
// Port-level checker for the typed draw batch allocator, bound to the top level.
// Depends on tdba_pkg and typed_draw_batch_allocator_macros.svh.
`include "typed_draw_batch_allocator_macros.svh"

module tdba_checker (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_req_valid,
    input logic              o_req_ready,
    input logic              o_res_valid,
    input logic              i_res_ready,
    input tdba_pkg::t_result o_res
);

    // a result only shows up after a request beat has passed the middle stage
    `TDBA_ASSERT_IMPL(a_res_follows_req, i_clk, i_rst_n, $rose(o_res_valid), $past(i_req_valid && o_req_ready, 2))

    // a refused add grants nothing
    `TDBA_ASSERT_IMPL(a_refused_add_empty, i_clk, i_rst_n, o_res_valid && (o_res.status == tdba_pkg::ST_OVER_CAP || o_res.status == tdba_pkg::ST_TABLE_FULL), o_res.start_index == 16'd0 && o_res.batch_index == 8'd0 && !o_res.new_batch)

    // a bad read slot returns zero record fields
    `TDBA_ASSERT_IMPL(a_bad_slot_zero, i_clk, i_rst_n, o_res_valid && o_res.status == tdba_pkg::ST_BAD_SLOT, o_res.read_kind == 2'd0 && o_res.read_start == 16'd0 && o_res.read_count == 16'd0)

    // stalled result beat holds
    `TDBA_ASSERT_NEXT(a_res_hold, i_clk, i_rst_n, o_res_valid && !i_res_ready, o_res_valid && $stable(o_res))

endmodule

bind typed_draw_batch_allocator tdba_checker u_tdba_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_req_valid (i_req_valid),
    .o_req_ready (o_req_ready),
    .o_res_valid (o_res_valid),
    .i_res_ready (i_res_ready),
    .o_res       (o_res)
);

>>> tb/tb_top.sv
// Self-checking bench for typed_draw_batch_allocator: directed and random request beats,
// results checked field by field against an in-bench allocator model.
// Depends on tdba_pkg and the RTL of the block.
module tb_top;
    import tdba_pkg::*;

    localparam int          BATCH_SLOTS   = 256;
    localparam int          ALIGN_BYTES   = 256;
    localparam int          RANDOM_ITEMS  = 1450;
    localparam int          HOLD_CYCLES   = 300;
    localparam int          DRAIN_PAUSE   = 6;
    localparam int unsigned CYCLE_LIMIT   = 600000;
    localparam int          PROF_FILL     = 0;
    localparam int          PROF_CAP      = 1;
    localparam int          PROF_MIX      = 2;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        req_valid = 1'b0;
    t_request    req = '0;
    logic        res_ready = 1'b0;
    logic        cfg_valid = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_data = '0;
    logic        req_ready;
    logic        res_valid;
    t_result     res;
    logic        cfg_ready;

    // allocator model state
    logic [3:0]  align_lg [3];
    logic [15:0] cap_reg [2];
    t_kind       open_kind;
    int unsigned rec_total;
    int unsigned next_slot [3];
    t_record     rec_mem [BATCH_SLOTS];

    t_result     predicted_results [$];

    int          sender_idle_pct = 0;
    int          stall_pct = 0;
    logic        hold_pending = 1'b0;
    int          hold_left = 0;
    logic [1:0]  prev_kind = KIND_ATLAS;
    int unsigned cycle_count = 0;
    int          n_err = 0;
    int          n_beats = 0;
    int          n_grants = 0;
    int          n_cap_refused = 0;
    int          n_full_refused = 0;
    int          n_reads = 0;
    int          n_bad_reads = 0;
    int          n_clears = 0;
    int          idle_modes [4][2] = '{'{0, 0}, '{74, 0}, '{0, 74}, '{9, 9}};

    typed_draw_batch_allocator DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_req_valid (req_valid),
        .o_req_ready (req_ready),
        .i_req       (req),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_res       (res),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    always #4 clk = ~clk;

    function automatic void reset_model();
        align_lg  = '{4'd1, 4'd1, 4'd3};
        cap_reg   = '{16'hFFFF, 16'hFFFF};
        open_kind = KIND_NONE;
        rec_total = 0;
        next_slot = '{0, 0, 0};
    endfunction

    function automatic int unsigned align_unit(int unsigned k);
        int unsigned u;
        u = 1 << align_lg[k];
        // oversized log2 values saturate at the byte alignment
        while (u > 1 && u > ALIGN_BYTES) u = u >> 1;
        return u;
    endfunction

    function automatic int unsigned slot_limit(int unsigned k);
        if (k == KIND_ATLAS) return cap_reg[0];
        if (k == KIND_PRIMITIVE) return cap_reg[1];
        return TEXT_LIMIT;
    endfunction

    function automatic t_result allocate_step(t_request r);
        t_result     o;
        int unsigned k, nxt, unit, base, fin;
        o = '0;
        k = r.item_kind;
        case (t_action'(r.action))
            ACT_ADD: begin
                if (r.item_kind != KIND_NONE) begin
                    nxt = next_slot[k];
                    if (open_kind == t_kind'(r.item_kind) && rec_total > 0) begin
                        fin = nxt + r.increment;
                        if (fin >= slot_limit(k)) begin
                            o.status = ST_OVER_CAP;
                        end else begin
                            rec_mem[rec_total - 1].count += r.increment;
                            next_slot[k]  = fin;
                            o.start_index = 16'(nxt);
                            o.batch_index = 8'(rec_total - 1);
                        end
                    end else begin
                        unit = align_unit(k);
                        base = (nxt + unit - 1) & ~(unit - 1);
                        fin  = base + r.increment;
                        if (fin >= slot_limit(k)) begin
                            o.status = ST_OVER_CAP;
                        end else if (rec_total >= BATCH_SLOTS) begin
                            o.status = ST_TABLE_FULL;
                        end else begin
                            rec_mem[rec_total] = '{kind: r.item_kind, start: 16'(base),
                                                   count: 16'(r.increment)};
                            o.batch_index = 8'(rec_total);
                            o.start_index = 16'(base);
                            o.new_batch   = 1'b1;
                            rec_total     = rec_total + 1;
                            open_kind     = t_kind'(r.item_kind);
                            next_slot[k]  = fin;
                        end
                    end
                end
            end
            ACT_CLEAR: begin
                rec_total = 0;
                open_kind = KIND_NONE;
                next_slot = '{0, 0, 0};
            end
            ACT_READ: begin
                if (r.batch_slot < rec_total) begin
                    o.read_kind  = rec_mem[r.batch_slot].kind;
                    o.read_start = rec_mem[r.batch_slot].start;
                    o.read_count = rec_mem[r.batch_slot].count;
                end else begin
                    o.status = ST_BAD_SLOT;
                end
            end
            default: ;
        endcase
        o.batch_total = 9'(rec_total);
        return o;
    endfunction

    function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            n_err++;
        end
    endfunction

    // Monitor: register writes, request beats into the model, result beats against it.
    always @(posedge clk) begin
        t_result want;
        if (rst_n) begin
            if (cfg_valid && cfg_ready) begin
                case (t_cfg_reg'(cfg_index))
                    CFG_ALIGN_ATLAS:     align_lg[0] = cfg_data[3:0];
                    CFG_ALIGN_PRIMITIVE: align_lg[1] = cfg_data[3:0];
                    CFG_ALIGN_TEXT:      align_lg[2] = cfg_data[3:0];
                    CFG_CAP_ATLAS:       cap_reg[0] = cfg_data;
                    CFG_CAP_PRIMITIVE:   cap_reg[1] = cfg_data;
                    default: ;
                endcase
            end
            if (req_valid && req_ready) begin
                want = allocate_step(req);
                predicted_results.push_back(want);
                n_beats++;
                case (t_action'(req.action))
                    ACT_ADD: begin
                        if (req.item_kind != KIND_NONE && want.status == ST_OK) n_grants++;
                        if (want.status == ST_OVER_CAP) n_cap_refused++;
                        if (want.status == ST_TABLE_FULL) n_full_refused++;
                    end
                    ACT_CLEAR: n_clears++;
                    ACT_READ: begin
                        if (want.status == ST_BAD_SLOT) n_bad_reads++;
                        else n_reads++;
                    end
                    default: ;
                endcase
            end
            if (res_valid && res_ready) begin
                if (predicted_results.size() == 0) begin
                    $error("result beat with no request outstanding");
                    n_err++;
                end else begin
                    want = predicted_results.pop_front();
                    check_field("start_index", want.start_index, res.start_index);
                    check_field("batch_index", 16'(want.batch_index), 16'(res.batch_index));
                    check_field("new_batch", 16'(want.new_batch), 16'(res.new_batch));
                    check_field("status", 16'(want.status), 16'(res.status));
                    check_field("batch_total", 16'(want.batch_total), 16'(res.batch_total));
                    check_field("read_kind", 16'(want.read_kind), 16'(res.read_kind));
                    check_field("read_start", want.read_start, res.read_start);
                    check_field("read_count", want.read_count, res.read_count);
                end
            end
        end
    end

    // Result side: random stalls, plus a long hold-off when the pressure test asks.
    always @(posedge clk) begin
        if (hold_pending) begin
            hold_pending <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            res_ready    <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            res_ready <= 1'b0;
        end else begin
            res_ready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, predicted_results.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    function automatic t_request beat(t_action act, logic [1:0] kind, int unsigned inc,
                                      int unsigned slot);
        return '{action: act, item_kind: kind, increment: 12'(inc), batch_slot: 8'(slot)};
    endfunction

    // valid stays up across back-to-back beats; it drops only for an idle gap
    task automatic send_req(t_request r);
        if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
            req_valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < sender_idle_pct);
        end
        req_valid <= 1'b1;
        req       <= r;
        do @(posedge clk); while (!req_ready);
    endtask

    task automatic wait_idle();
        req_valid <= 1'b0;
        @(posedge clk);
        while (predicted_results.size() != 0) @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    task automatic write_reg(t_cfg_reg idx, logic [15:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (!cfg_ready);
    endtask

    task automatic configure(logic [3:0] lg_a, logic [3:0] lg_p, logic [3:0] lg_t,
                             logic [15:0] cap_a, logic [15:0] cap_p);
        wait_idle();
        write_reg(CFG_ALIGN_ATLAS, 16'(lg_a));
        write_reg(CFG_ALIGN_PRIMITIVE, 16'(lg_p));
        write_reg(CFG_ALIGN_TEXT, 16'(lg_t));
        write_reg(CFG_CAP_ATLAS, cap_a);
        write_reg(CFG_CAP_PRIMITIVE, cap_p);
        cfg_valid <= 1'b0;
    endtask

    function automatic logic [3:0] pick_align();
        case ($urandom_range(5))
            0:       return 4'd0;
            1:       return 4'd8;
            2:       return 4'd15;
            default: return 4'($urandom_range(15));
        endcase
    endfunction

    function automatic logic [15:0] pick_cap();
        case ($urandom_range(5))
            0:       return 16'd0;
            1:       return 16'hFFFF;
            2:       return 16'($urandom_range(1, 4096));
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_request make_req(int profile);
        t_request r;
        int       roll;
        roll = $urandom_range(99);
        r = beat(ACT_ADD, KIND_ATLAS, $urandom, $urandom);
        case (profile)
            PROF_FILL: begin
                // mostly kind switches so records pile up toward a full table
                r.increment = 12'($urandom_range(3));
                if ($urandom_range(9) == 0) r.item_kind = prev_kind;
                else r.item_kind = 2'((int'(prev_kind) + $urandom_range(1, 2)) % 3);
                if (roll < 15) begin
                    r.action     = ACT_READ;
                    r.batch_slot = 8'($urandom_range(rec_total));
                end else if (roll < 17) begin
                    r.action = ACT_NONE;
                end else if (roll < 19) begin
                    r.item_kind = KIND_NONE;
                end
            end
            PROF_CAP: begin
                r.item_kind = 2'($urandom_range(2));
                if (roll < 80) r.increment = 12'($urandom_range(2500, 4095));
                if (roll >= 88 && roll < 98) begin
                    r.action     = ACT_READ;
                    r.batch_slot = 8'($urandom_range(rec_total));
                end else if (roll >= 98) begin
                    r.action = ACT_CLEAR;
                end
            end
            default: begin
                r.item_kind = 2'($urandom_range(3));
                if ($urandom_range(1) == 0) r.increment = 12'($urandom_range(15));
                if (roll >= 55 && roll < 80) r.action = ACT_READ;
                else if (roll >= 80 && roll < 84) r.action = ACT_CLEAR;
                else if (roll >= 84) r.action = 2'($urandom_range(3));
            end
        endcase
        if (r.action == ACT_ADD && r.item_kind != KIND_NONE) prev_kind = r.item_kind;
        return r;
    endfunction

    task automatic test_basic_allocation();
        send_req(beat(ACT_ADD, KIND_ATLAS, 3, 0));
        send_req(beat(ACT_ADD, KIND_ATLAS, 5, 0));
        send_req(beat(ACT_ADD, KIND_TEXT, 4095, 255));
        send_req(beat(ACT_ADD, KIND_TEXT, 0, 0));
        send_req(beat(ACT_ADD, KIND_ATLAS, 1, 0));
        send_req(beat(ACT_ADD, KIND_PRIMITIVE, 0, 0));
        send_req(beat(ACT_ADD, KIND_NONE, 4095, 255));
        send_req(beat(ACT_NONE, KIND_NONE, 4095, 255));
        send_req(beat(ACT_READ, KIND_ATLAS, 0, 0));
        send_req(beat(ACT_READ, KIND_ATLAS, 0, 1));
        send_req(beat(ACT_READ, KIND_ATLAS, 0, 2));
        send_req(beat(ACT_READ, KIND_TEXT, 4095, 3));
        send_req(beat(ACT_READ, KIND_ATLAS, 0, 4));
        send_req(beat(ACT_READ, KIND_ATLAS, 0, 255));
        send_req(beat(ACT_CLEAR, KIND_NONE, 4095, 255));
        send_req(beat(ACT_READ, KIND_ATLAS, 0, 0));
        send_req(beat(ACT_ADD, KIND_ATLAS, 7, 0));
    endtask

    task automatic test_register_extremes();
        configure(4'd0, 4'd8, 4'd15, 16'd0, 16'hFFFF);
        send_req(beat(ACT_CLEAR, KIND_ATLAS, 0, 0));
        send_req(beat(ACT_ADD, KIND_ATLAS, 1, 0));
        send_req(beat(ACT_ADD, KIND_PRIMITIVE, 4095, 0));
        send_req(beat(ACT_ADD, KIND_TEXT, 5, 0));
        send_req(beat(ACT_ADD, KIND_PRIMITIVE, 4095, 0));
        // counters survive a register write; the clear below resets them
        configure(4'd15, 4'd0, 4'd8, 16'hFFFF, 16'd4096);
        send_req(beat(ACT_ADD, KIND_TEXT, 1, 0));
        send_req(beat(ACT_CLEAR, KIND_ATLAS, 0, 0));
        send_req(beat(ACT_ADD, KIND_PRIMITIVE, 4095, 0));
        send_req(beat(ACT_ADD, KIND_PRIMITIVE, 1, 0));
        send_req(beat(ACT_ADD, KIND_PRIMITIVE, 0, 0));
        send_req(beat(ACT_ADD, KIND_ATLAS, 4095, 0));
        send_req(beat(ACT_ADD, KIND_ATLAS, 4095, 0));
        send_req(beat(ACT_READ, KIND_ATLAS, 0, 1));
    endtask

    task automatic test_table_full();
        sender_idle_pct = idle_modes[3][0];
        stall_pct       = idle_modes[3][1];
        configure(4'd0, 4'd0, 4'd0, 16'hFFFF, 16'hFFFF);
        send_req(beat(ACT_CLEAR, KIND_ATLAS, 0, 0));
        for (int i = 0; i < BATCH_SLOTS; i++) begin
            send_req(beat(ACT_ADD, (i % 2) ? KIND_PRIMITIVE : KIND_ATLAS,
                          $urandom_range(3), 0));
        end
        // last open batch is primitive: another kind is refused, primitive still grows
        send_req(beat(ACT_ADD, KIND_ATLAS, 1, 0));
        send_req(beat(ACT_ADD, KIND_TEXT, 0, 0));
        send_req(beat(ACT_ADD, KIND_PRIMITIVE, 2, 0));
        send_req(beat(ACT_READ, KIND_ATLAS, 0, 255));
        send_req(beat(ACT_READ, KIND_ATLAS, 0, 0));
        sender_idle_pct = 0;
        stall_pct       = 0;
    endtask

    task automatic test_output_backpressure();
        configure(4'd2, 4'd1, 4'd3, 16'hFFFF, 16'hFFFF);
        hold_pending <= 1'b1;
        repeat (60) send_req(make_req(PROF_MIX));
    endtask

    task automatic test_random_traffic();
        int       phase;
        int       made;
        int       prof;
        int       len;
        t_request r;
        phase = 0;
        made  = 0;
        while (made < RANDOM_ITEMS) begin
            prof = phase % 3;
            if (prof == PROF_FILL) configure(pick_align(), pick_align(), pick_align(),
                                             16'hFFFF, 16'hFFFF);
            else configure(pick_align(), pick_align(), pick_align(), pick_cap(), pick_cap());
            sender_idle_pct = idle_modes[phase % 4][0];
            stall_pct       = idle_modes[phase % 4][1];
            send_req(beat(ACT_CLEAR, KIND_ATLAS, 0, 0));
            len = (prof == PROF_FILL) ? 380 : (prof == PROF_CAP) ? 70 : 120;
            repeat (len) begin
                r = make_req(prof);
                if (!(r.action == ACT_NONE || (r.action == ACT_ADD && r.item_kind == KIND_NONE)))
                    made++;
                send_req(r);
            end
            phase++;
        end
        sender_idle_pct = 0;
        stall_pct       = 0;
    endtask

    initial begin
        reset_model();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_allocation();
        test_register_extremes();
        test_table_full();
        test_output_backpressure();
        test_random_traffic();
        wait_idle();
        if (predicted_results.size() != 0) begin
            $error("%0d results never arrived", predicted_results.size());
            n_err++;
        end
        $display("covered %0d request beats: %0d adds granted, %0d over capacity, %0d table full",
                 n_beats, n_grants, n_cap_refused, n_full_refused);
        $display("  %0d record reads, %0d bad slot reads, %0d frame clears, %0d mismatches",
                 n_reads, n_bad_reads, n_clears, n_err);
        if (n_err == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
